// ===== hdl/lsaf_pkg.sv =====
// lsaf_pkg: shared types and constants for the line sensor array front end
// ops, control state, lane control group and fixed output field widths
// no dependencies
package lsaf_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int NUM_CHAN = 5;
	localparam int NORM_BITS = 10;
	localparam int ERR_BITS = 14;
	localparam int DIV_STEPS = NORM_BITS;
	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [NORM_BITS-1:0] NORM_FULL = NORM_BITS'(1000);
	localparam int OP_BITS = 2;
	localparam int OUT_FIELD_W = 1 + ERR_BITS + NUM_CHAN * NORM_BITS;
	localparam int OUT_DATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELD_W;

	typedef enum logic [OP_BITS-1:0] {
		OP_CAL_START = 2'd0,
		OP_CAL_WIDEN = 2'd1,
		OP_MEASURE   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_HOLD
	} fsm_t;

	typedef struct packed {
		logic cal_start;
		logic cal_widen;
		logic meas_start;
		logic mul_en;
		logic div_en;
		logic load;
	} ctrl_t;

endpackage

// ===== hdl/lsaf_lane.sv =====
// lsaf_lane: one sensor channel with calibration registers, threshold compare
// and a serial restoring divider for the 0..1000 scaling
// depends on lsaf_pkg
module lsaf_lane import lsaf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_t                  ctrl,
	input  logic                   dark,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   hit,
	output logic [NORM_BITS-1:0]   norm
);

	localparam int NW = SAMPLE_BITS + NORM_BITS;

	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] thr_q;
	logic                   hit_q;
	logic                   zero_q;
	logic                   sat_q;
	logic [SAMPLE_BITS-1:0] diff_q;
	logic [SAMPLE_BITS-1:0] span_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [NORM_BITS-1:0]   quo_q;

	logic [SAMPLE_BITS-1:0] wmin;
	logic [SAMPLE_BITS-1:0] wmax;
	logic [SAMPLE_BITS:0]   wsum;
	logic [NW-1:0]          num;
	logic [SAMPLE_BITS:0]   trial;
	logic [SAMPLE_BITS:0]   sub;
	logic                   ge;

	assign wmin = (sample < min_q) ? sample : min_q;
	assign wmax = (sample > max_q) ? sample : max_q;
	assign wsum = {1'b0, wmin} + {1'b0, wmax};
	assign num = NW'(diff_q) * NW'(NORM_FULL);
	assign trial = {rem_q, quo_q[NORM_BITS-1]};
	assign sub = trial - {1'b0, span_q};
	assign ge = trial >= {1'b0, span_q};

	// calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
			thr_q <= '0;
		end else if (ctrl.cal_start) begin
			min_q <= sample;
			max_q <= sample;
			thr_q <= sample;
		end else if (ctrl.cal_widen) begin
			min_q <= wmin;
			max_q <= wmax;
			thr_q <= wsum[SAMPLE_BITS:1];
		end
	end

	// measure path and divider
	always_ff @(posedge clk) begin
		if (ctrl.meas_start) begin
			hit_q <= dark ? (sample > thr_q) : (sample < thr_q);
			zero_q <= !((max_q > min_q) && (sample > min_q));
			sat_q <= sample >= max_q;
			diff_q <= sample - min_q;
			span_q <= max_q - min_q;
		end
		if (ctrl.mul_en) begin
			rem_q <= num[NW-1:NORM_BITS];
			quo_q <= num[NORM_BITS-1:0];
		end else if (ctrl.div_en) begin
			rem_q <= ge ? sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
			quo_q <= {quo_q[NORM_BITS-2:0], ge};
		end
	end

	assign hit = hit_q;
	assign norm = zero_q ? '0 : (sat_q ? NORM_FULL : quo_q);

endmodule

// ===== hdl/lsaf_merge.sv =====
// lsaf_merge: combines lane results, computes the weighted position error
// and holds the result register on the master side
// depends on lsaf_pkg
module lsaf_merge import lsaf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ctrl_t                                 ctrl,
	input  logic                                  dark,
	input  logic [NUM_CHAN-1:0][SAMPLE_BITS-1:0]  samples,
	input  logic [NUM_CHAN-1:0]                   hits,
	input  logic [NUM_CHAN-1:0][NORM_BITS-1:0]    norms,
	output logic                                  out_free,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [OUT_DATA_W-1:0]                 m_tdata
);

	localparam int EW = SAMPLE_BITS + 4;
	localparam int XW = (EW > ERR_BITS) ? EW : ERR_BITS;

	logic signed [XW-1:0] a0;
	logic signed [XW-1:0] a1;
	logic signed [XW-1:0] a3;
	logic signed [XW-1:0] a4;
	logic signed [XW-1:0] err_raw;
	logic signed [XW-1:0] err_fix;
	logic [ERR_BITS-1:0]  err_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign a0 = signed'(XW'(samples[0]));
	assign a1 = signed'(XW'(samples[1]));
	assign a3 = signed'(XW'(samples[3]));
	assign a4 = signed'(XW'(samples[4]));
	assign err_raw = (a0 <<< 1) + a0 + (a1 <<< 1) - (a3 <<< 1) - ((a4 <<< 1) + a4);
	assign err_fix = dark ? -err_raw : err_raw;

	always_ff @(posedge clk) begin
		if (ctrl.meas_start) begin
			err_q <= err_fix[ERR_BITS-1:0];
		end
		if (ctrl.load) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, norms, err_q, |hits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

// ===== hdl/line_sensor_array_frontend_unit.sv =====
// line_sensor_array_frontend_unit: five-channel line sensor calibration and measure
// calibration requests give no result; a measure request gives its result after capture,
// multiply, one divider step per quotient bit and load; requests are taken only while idle,
// one calibration per cycle; a measure blocks requests until loaded, which waits for output room
// arst_n clears calibration to zero, line_is_dark to 0, the control state and the result valid flag
// depends on lsaf_pkg, lsaf_lane, lsaf_merge
module line_sensor_array_frontend_unit import lsaf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,   // line_is_dark
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((NUM_CHAN*SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample_0..sample_4
	input  logic [OP_BITS-1:0]            s_tuser,     // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OUT_DATA_W-1:0]         m_tdata      // on_line, position_error, norm_0..norm_4
);

	logic                                 dark_q;
	fsm_t                                 state_q;
	fsm_t                                 state_nxt;
	logic [CNT_W-1:0]                     cnt_q;
	ctrl_t                                ctrl;
	logic                                 acc;
	logic                                 out_free;
	op_t                                  op;
	logic [NUM_CHAN-1:0][SAMPLE_BITS-1:0] samples;
	logic [NUM_CHAN-1:0]                  hits;
	logic [NUM_CHAN-1:0][NORM_BITS-1:0]   norms;

	assign op = op_t'(s_tuser);
	assign samples = s_tdata[NUM_CHAN*SAMPLE_BITS-1:0];
	assign acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q <= 1'b0;
		end else if (cfg_we) begin
			dark_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_MUL) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && op == OP_MEASURE) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_nxt = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready = state_q == ST_IDLE;
		ctrl = '0;
		ctrl.mul_en = state_q == ST_MUL;
		ctrl.div_en = state_q == ST_DIV;
		ctrl.load = (state_q == ST_HOLD) && out_free;
		if (acc) begin
			unique case (op)
				OP_CAL_START: ctrl.cal_start = 1'b1;
				OP_CAL_WIDEN: ctrl.cal_widen = 1'b1;
				OP_MEASURE:   ctrl.meas_start = 1'b1;
				default:      ctrl.meas_start = 1'b0;
			endcase
		end
	end

	for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
		lsaf_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.dark   (dark_q),
			.sample (samples[g]),
			.hit    (hits[g]),
			.norm   (norms[g])
		);
	end

	lsaf_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.dark     (dark_q),
		.samples  (samples),
		.hits     (hits),
		.norms    (norms),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== tb/line_sensor_array_frontend_unit_tb.sv =====
// line_sensor_array_frontend_unit_tb: self-checking bench for the sensor front end
// directed table then calibrate/measure bursts under random idling, scored by a predictor
// depends on lsaf_pkg and line_sensor_array_frontend_unit
`timescale 1ns / 100ps

module line_sensor_array_frontend_unit_tb;
	import lsaf_pkg::*;

	localparam int IN_DATA_W = ((NUM_CHAN * SAMPLE_BITS_DEF + 7) / 8) * 8;
	localparam logic [OP_BITS-1:0] OP_IGNORED = 2'd3;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_REPORTS = 40;

	typedef logic [NUM_CHAN-1:0][SAMPLE_BITS_DEF-1:0] frame_t;

	// packed so that on_line sits at bit 0, as on m_tdata
	typedef struct packed {
		logic [NUM_CHAN-1:0][NORM_BITS-1:0] norm;
		logic [ERR_BITS-1:0]                err;
		logic                               on_line;
	} reading_t;

	typedef struct {
		bit                 is_cfg;
		bit                 cfg_val;
		logic [OP_BITS-1:0] op;
		frame_t             samples;
		bit                 fixed;
		reading_t           fixed_reading;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic                 cfg_wdata = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [OP_BITS-1:0]   s_tuser = OP_CAL_START;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	line_sensor_array_frontend_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("line_sensor_array_frontend_unit: mismatch");
		$finish;
	end

	// predictor state
	logic [SAMPLE_BITS_DEF-1:0] cal_lo [NUM_CHAN];
	logic [SAMPLE_BITS_DEF-1:0] cal_hi [NUM_CHAN];
	logic [SAMPLE_BITS_DEF-1:0] cal_mid[NUM_CHAN];
	bit                         dark_line;

	reading_t readings_due[$];
	bit       offer_fixed = 1'b0;
	reading_t offer_reading = '0;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int requests_taken = 0;
	int readings_checked = 0;
	int cfg_writes = 0;
	int measures_sent = 0;
	int errors = 0;

	task automatic sensor_step(input logic [OP_BITS-1:0] op, input frame_t s,
			output bit made, output reading_t r);
		int lo;
		int hi;
		int v;
		int q;
		int acc;
		made = 1'b0;
		r = '0;
		case (op)
			OP_CAL_START, OP_CAL_WIDEN: begin
				for (int i = 0; i < NUM_CHAN; i++) begin
					if (op == OP_CAL_START) begin
						cal_lo[i] = s[i];
						cal_hi[i] = s[i];
					end else begin
						if (s[i] < cal_lo[i]) cal_lo[i] = s[i];
						if (s[i] > cal_hi[i]) cal_hi[i] = s[i];
					end
					cal_mid[i] = SAMPLE_BITS_DEF'((int'(cal_lo[i]) + int'(cal_hi[i])) >> 1);
				end
			end
			OP_MEASURE: begin
				made = 1'b1;
				for (int i = 0; i < NUM_CHAN; i++) begin
					if (dark_line ? (s[i] > cal_mid[i]) : (s[i] < cal_mid[i]))
						r.on_line = 1'b1;
					lo = cal_lo[i];
					hi = cal_hi[i];
					v = s[i];
					if (hi <= lo || v <= lo) begin
						q = 0;
					end else begin
						q = ((v - lo) * 1000) / (hi - lo);
						if (q > 1000) q = 1000;
					end
					r.norm[i] = NORM_BITS'(q);
				end
				acc = 3 * int'(s[0]) + 2 * int'(s[1]) - 2 * int'(s[3]) - 3 * int'(s[4]);
				if (dark_line) acc = -acc;
				r.err = ERR_BITS'(acc);
			end
			default: ;
		endcase
	endtask

	task automatic flag_field(string name, int want, int got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
	endtask

	always @(posedge clk) begin : scoreboard
		reading_t got;
		reading_t want;
		reading_t calc;
		bit made;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_FIELD_W-1:0];
				readings_checked++;
				if (readings_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, got %h", $time, got);
				end else begin
					want = readings_due.pop_front();
					if (got.on_line !== want.on_line)
						flag_field("on_line", want.on_line, got.on_line);
					if (got.err !== want.err)
						flag_field("position_error", $signed(want.err), $signed(got.err));
					for (int i = 0; i < NUM_CHAN; i++)
						if (got.norm[i] !== want.norm[i])
							flag_field($sformatf("norm_%0d", i), want.norm[i], got.norm[i]);
				end
			end
			if (s_tvalid && s_tready) begin
				requests_taken++;
				sensor_step(s_tuser, s_tdata[NUM_CHAN*SAMPLE_BITS_DEF-1:0], made, calc);
				if (made)
					readings_due.push_back(offer_fixed ? offer_reading : calc);
			end
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	task automatic put_request(logic [OP_BITS-1:0] op, frame_t s, bit fixed,
			reading_t fixed_reading);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_DATA_W'(s);
		offer_fixed <= fixed;
		offer_reading <= fixed_reading;
		if (op == OP_MEASURE) measures_sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (readings_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// only while idle: no request offered and nothing in flight
	task automatic set_polarity(bit dark);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= dark;
		@(negedge clk);
		cfg_we <= 1'b0;
		dark_line = dark;
		cfg_writes++;
	endtask

	function automatic plan_row_t req_row(logic [OP_BITS-1:0] op, int s0, int s1, int s2,
			int s3, int s4, bit fixed = 1'b0, bit on = 1'b0, int err = 0, int norm_all = 0);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.cfg_val = 1'b0;
		row.op = op;
		row.samples = {10'(s4), 10'(s3), 10'(s2), 10'(s1), 10'(s0)};
		row.fixed = fixed;
		row.fixed_reading.on_line = on;
		row.fixed_reading.err = ERR_BITS'(err);
		for (int i = 0; i < NUM_CHAN; i++)
			row.fixed_reading.norm[i] = NORM_BITS'(norm_all);
		return row;
	endfunction

	function automatic plan_row_t cfg_row(bit dark);
		plan_row_t row;
		row = req_row(OP_CAL_START, 0, 0, 0, 0, 0);
		row.is_cfg = 1'b1;
		row.cfg_val = dark;
		return row;
	endfunction

	function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return SAMPLE_BITS_DEF'($urandom_range(1023));
		endcase
	endfunction

	function automatic frame_t pick_frame();
		frame_t f;
		for (int i = 0; i < NUM_CHAN; i++)
			f[i] = pick_sample();
		return f;
	endfunction

	task automatic random_phase(int count);
		int done;
		done = 0;
		while (done < count) begin
			if ($urandom_range(99) < 85) begin
				put_request(OP_CAL_START, pick_frame(), 1'b0, '0);
				done++;
				repeat ($urandom_range(4, 1)) begin
					put_request(OP_CAL_WIDEN, pick_frame(), 1'b0, '0);
					done++;
				end
				repeat ($urandom_range(6, 2)) begin
					put_request(OP_MEASURE, pick_frame(), 1'b0, '0);
					done++;
				end
			end else begin
				logic [OP_BITS-1:0] op;
				op = OP_BITS'($urandom_range(3));
				put_request(op, pick_frame(), 1'b0, '0);
				done++;
			end
		end
	endtask

	plan_row_t plan[$];

	initial begin
		for (int i = 0; i < NUM_CHAN; i++) begin
			cal_lo[i] = '0;
			cal_hi[i] = '0;
			cal_mid[i] = '0;
		end
		dark_line = 1'b0;

		// uncalibrated, then calibration edge cases, then dark line
		plan.push_back(req_row(OP_MEASURE, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		plan.push_back(req_row(OP_MEASURE, 1023, 1023, 512, 0, 0, 1, 0, 5115, 0));
		plan.push_back(req_row(OP_MEASURE, 0, 0, 1023, 1023, 1023, 1, 0, -5115, 0));
		plan.push_back(req_row(OP_IGNORED, 1023, 1023, 1023, 1023, 1023));
		plan.push_back(req_row(OP_CAL_WIDEN, 100, 200, 300, 400, 500));
		plan.push_back(req_row(OP_MEASURE, 50, 150, 300, 399, 1023));
		plan.push_back(req_row(OP_CAL_START, 0, 0, 0, 0, 0));
		plan.push_back(req_row(OP_CAL_WIDEN, 1023, 1023, 1023, 1023, 1023));
		plan.push_back(req_row(OP_MEASURE, 1023, 1023, 1023, 1023, 1023, 1, 0, 0, 1000));
		plan.push_back(req_row(OP_MEASURE, 0, 0, 0, 0, 0, 1, 1, 0, 0));
		plan.push_back(req_row(OP_MEASURE, 511, 512, 510, 1, 1022));
		plan.push_back(req_row(OP_CAL_START, 300, 300, 300, 300, 300));
		plan.push_back(req_row(OP_MEASURE, 300, 500, 0, 299, 301));
		plan.push_back(req_row(OP_CAL_START, 100, 100, 100, 100, 100));
		plan.push_back(req_row(OP_CAL_WIDEN, 900, 900, 900, 900, 900));
		plan.push_back(req_row(OP_MEASURE, 50, 1000, 500, 100, 900));
		plan.push_back(req_row(OP_IGNORED, 0, 0, 0, 0, 0));
		plan.push_back(req_row(OP_MEASURE, 'h2AA, 'h155, 'h2AA, 'h155, 'h2AA));
		plan.push_back(cfg_row(1'b1));
		plan.push_back(req_row(OP_MEASURE, 1023, 1023, 0, 0, 0));
		plan.push_back(req_row(OP_MEASURE, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		plan.push_back(req_row(OP_CAL_START, 0, 0, 0, 0, 0));
		plan.push_back(req_row(OP_CAL_WIDEN, 1023, 1023, 1023, 1023, 1023));
		plan.push_back(req_row(OP_MEASURE, 1023, 1023, 1023, 1023, 1023, 1, 1, 0, 1000));
		plan.push_back(cfg_row(1'b0));

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[k]) begin
			if (plan[k].is_cfg)
				set_polarity(plan[k].cfg_val);
			else
				put_request(plan[k].op, plan[k].samples, plan[k].fixed, plan[k].fixed_reading);
		end

		for (int ph = 0; ph < 4; ph++) begin
			set_polarity(ph[0]);
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
				default: begin src_idle_pct = 23; sink_stall_pct = 23; end
			endcase
			random_phase(150);
		end
		src_idle_pct = 0;
		sink_stall_pct = 0;
		drain();

		$display("%0d requests taken (%0d measures), %0d results checked, %0d polarity writes",
			requests_taken, measures_sent, readings_checked, cfg_writes);
		$display("idling phases: none, sender 77%%, receiver 77%%, both 23%%; %0d errors", errors);
		if (errors == 0)
			$display("line_sensor_array_frontend_unit: match");
		else
			$display("line_sensor_array_frontend_unit: mismatch");
		$finish;
	end

endmodule
